[hw/rtl/hkmp_pkg.sv]
package hkmp_pkg;

    localparam int NUM_WAIT_REGS = 4;
    localparam int STR_CHARS     = 31;

    // commands
    localparam logic [1:0] CMD_POLL   = 2'd0;
    localparam logic [1:0] CMD_START1 = 2'd1;
    localparam logic [1:0] CMD_START2 = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_WAIT_BEFORE_A = 2'd0;
    localparam logic [1:0] REG_WAIT_AFTER_A  = 2'd1;
    localparam logic [1:0] REG_WAIT_BEFORE_B = 2'd2;
    localparam logic [1:0] REG_WAIT_AFTER_B  = 2'd3;

    localparam logic [31:0] WAIT_BEFORE_A_RST = 32'd96000000;
    localparam logic [31:0] WAIT_AFTER_A_RST  = 32'd192000000;
    localparam logic [31:0] WAIT_BEFORE_B_RST = 32'd96000000;
    localparam logic [31:0] WAIT_AFTER_B_RST  = 32'd48000000;

    // script steps
    localparam logic [3:0] STEP_SCRIPT1      = 4'd0;
    localparam logic [3:0] STEP_SCRIPT2      = 4'd5;
    localparam logic [3:0] STEP_BUTTON_RESET = 4'd4;
    localparam logic [3:0] STEP_LAST         = 4'd9;

    // step kinds
    localparam logic [1:0] KIND_SLEEP = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_STR   = 2'd2;
    localparam logic [1:0] KIND_BTN   = 2'd3;

    localparam logic [7:0] USAGE_LEFT_ARROW  = 8'h50;
    localparam logic [7:0] USAGE_RIGHT_ARROW = 8'h4F;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_first;
        logic [7:0] key_slot_second;
    } hkmp_report_t;

    typedef struct packed {
        logic        advance;
        logic [1:0]  cmd;
        logic [31:0] now_ticks;
        logic        button_left;
        logic        button_right;
    } hkmp_item_t;

    function automatic logic [1:0] step_kind_f(input logic [3:0] step);
        logic [1:0] k;
        case (step)
            4'd0, 4'd2, 4'd5, 4'd7: k = KIND_SLEEP;
            4'd1, 4'd6:             k = KIND_KEY;
            4'd3, 4'd8:             k = KIND_STR;
            default:                k = KIND_BTN;
        endcase
        return k;
    endfunction

    // wait register for sleeps, key index for keys, start position for strings
    function automatic logic [1:0] step_arg_f(input logic [3:0] step);
        logic [1:0] a;
        case (step)
            4'd2:    a = 2'd1;
            4'd5:    a = 2'd2;
            4'd6:    a = 2'd1;
            4'd7:    a = 2'd3;
            4'd8:    a = 2'd1;
            default: a = 2'd0;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] key_mod_f(input logic idx);
        return idx ? 8'h08 : 8'h00;
    endfunction

    function automatic logic [7:0] key_code_f(input logic idx);
        return idx ? 8'h15 : 8'hF0;
    endfunction

    function automatic logic [7:0] str_mod_f(input logic [4:0] pos);
        logic [7:0] m;
        case (pos)
            5'd0:                                  m = 8'd1;
            5'd6, 5'd7, 5'd8, 5'd17, 5'd20, 5'd25: m = 8'd2;
            default:                               m = 8'd0;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] str_code_f(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = 8'h0F;
            5'd1:    c = 8'h0B;
            5'd2:    c = 8'h17;
            5'd3:    c = 8'h17;
            5'd4:    c = 8'h13;
            5'd5:    c = 8'h16;
            5'd6:    c = 8'h37;
            5'd7:    c = 8'h24;
            5'd8:    c = 8'h24;
            5'd9:    c = 8'h09;
            5'd10:   c = 8'h16;
            5'd11:   c = 8'h38;
            5'd12:   c = 8'h08;
            5'd13:   c = 8'h0C;
            5'd14:   c = 8'h37;
            5'd15:   c = 8'h07;
            5'd16:   c = 8'h08;
            5'd17:   c = 8'h24;
            5'd18:   c = 8'h07;
            5'd19:   c = 8'h08;
            5'd20:   c = 8'h24;
            5'd21:   c = 8'h1B;
            5'd22:   c = 8'h10;
            5'd23:   c = 8'h04;
            5'd24:   c = 8'h16;
            5'd25:   c = 8'h38;
            5'd26:   c = 8'h06;
            5'd27:   c = 8'h04;
            5'd28:   c = 8'h15;
            5'd29:   c = 8'h07;
            5'd30:   c = 8'h28;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[hw/rtl/hkmp_cfg_regs.sv]
module hkmp_cfg_regs
    import hkmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] wait_values [NUM_WAIT_REGS]
);

    logic [31:0] wait_reg [NUM_WAIT_REGS];
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg[REG_WAIT_BEFORE_A] <= WAIT_BEFORE_A_RST;
            wait_reg[REG_WAIT_AFTER_A]  <= WAIT_AFTER_A_RST;
            wait_reg[REG_WAIT_BEFORE_B] <= WAIT_BEFORE_B_RST;
            wait_reg[REG_WAIT_AFTER_B]  <= WAIT_AFTER_B_RST;
        end
        else if (wr_en)
        begin
            wait_reg[reg_idx] <= pwdata;
        end
    end

    assign prdata      = wait_reg[reg_idx];
    assign wait_values = wait_reg;

endmodule

[hw/rtl/hkmp_engine.sv]
module hkmp_engine
    import hkmp_pkg::*;
#(
    parameter int STRING_DEPTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  hkmp_item_t   item,
    input  logic [31:0]  wait_values [NUM_WAIT_REGS],
    output logic         has_result,
    output hkmp_report_t report
);

    // string end position (exclusive): the first position that is not played
    localparam int          StrEndInt = (STRING_DEPTH - 1 < STR_CHARS) ?
                                        STRING_DEPTH - 1 : STR_CHARS;
    localparam logic [4:0]  STR_END   = 5'(StrEndInt);

    logic [3:0]  script_step_reg,   script_step_next;
    logic [4:0]  char_position_reg, char_position_next;
    logic [1:0]  hold_phase_reg,    hold_phase_next;
    logic [31:0] sleep_start_reg,   sleep_start_next;

    logic [1:0]  kind;
    logic [1:0]  arg;
    logic [31:0] elapsed;
    logic        enter_en;
    logic [3:0]  enter_step;
    logic [1:0]  enter_kind;
    logic        str_end;

    assign kind       = step_kind_f(script_step_reg);
    assign arg        = step_arg_f(script_step_reg);
    assign elapsed    = item.now_ticks - sleep_start_reg;
    assign str_end    = (char_position_reg >= STR_END);

    always_comb
    begin
        has_result         = 1'b0;
        report             = '0;
        enter_en           = 1'b0;
        enter_step         = script_step_reg + 4'd1;
        hold_phase_next    = hold_phase_reg;
        char_position_next = char_position_reg;

        case (item.cmd)
            CMD_START1:
            begin
                enter_en   = 1'b1;
                enter_step = STEP_SCRIPT1;
            end
            CMD_START2:
            begin
                enter_en   = 1'b1;
                enter_step = STEP_SCRIPT2;
            end
            CMD_POLL:
            begin
                has_result = 1'b1;
                case (kind)
                    KIND_SLEEP:
                    begin
                        enter_en = (elapsed >= wait_values[arg]);
                    end
                    KIND_KEY:
                    begin
                        if (hold_phase_reg <= 2'd1)
                        begin
                            report.modifier_bits  = key_mod_f(arg[0]);
                            report.key_slot_first = key_code_f(arg[0]);
                            hold_phase_next       = hold_phase_reg + 2'd1;
                        end
                        else
                        begin
                            enter_en = 1'b1;
                        end
                    end
                    KIND_STR:
                    begin
                        if (!str_end)
                        begin
                            if (hold_phase_reg <= 2'd1)
                            begin
                                report.modifier_bits  = str_mod_f(char_position_reg);
                                report.key_slot_first = str_code_f(char_position_reg);
                            end
                            // 2-bit phase wraps 3 -> 0 on release end
                            hold_phase_next = hold_phase_reg + 2'd1;
                            if (hold_phase_reg == 2'd3)
                            begin
                                char_position_next = char_position_reg + 5'd1;
                            end
                        end
                        else
                        begin
                            enter_en = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (item.button_left)
                        begin
                            report.key_slot_first = USAGE_LEFT_ARROW;
                            if (item.button_right)
                            begin
                                report.key_slot_second = USAGE_RIGHT_ARROW;
                            end
                        end
                        else if (item.button_right)
                        begin
                            report.key_slot_first = USAGE_RIGHT_ARROW;
                        end
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        enter_kind       = step_kind_f(enter_step);
        script_step_next = script_step_reg;
        sleep_start_next = sleep_start_reg;
        if (enter_en)
        begin
            script_step_next = enter_step;
            case (enter_kind)
                KIND_SLEEP:
                begin
                    sleep_start_next = item.now_ticks;
                end
                KIND_KEY:
                begin
                    hold_phase_next = 2'd0;
                end
                KIND_STR:
                begin
                    hold_phase_next    = 2'd0;
                    char_position_next = {3'd0, step_arg_f(enter_step)};
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            script_step_reg   <= STEP_BUTTON_RESET;
            char_position_reg <= '0;
            hold_phase_reg    <= '0;
            sleep_start_reg   <= '0;
        end
        else if (item.advance)
        begin
            script_step_reg   <= script_step_next;
            char_position_reg <= char_position_next;
            hold_phase_reg    <= hold_phase_next;
            sleep_start_reg   <= sleep_start_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        script_step_reg <= STEP_LAST)
        else $error("script step out of range");

    a_key_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (kind == KIND_KEY) |-> (hold_phase_reg <= 2'd2))
        else $error("key hold phase overran");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        char_position_reg <= STR_END)
        else $error("string position past end");

    a_start_sleep: assert property (@(posedge clk) disable iff (!rst_n)
        (item.advance && (item.cmd == CMD_START1 || item.cmd == CMD_START2))
        |=> (kind == KIND_SLEEP) && (sleep_start_reg == $past(item.now_ticks)))
        else $error("start command did not enter sleep");
`endif

endmodule

[hw/rtl/hid_keystroke_macro_player_unit.sv]
// Path: a transaction waits in the input register; a poll's report then goes to the output
//   register. Throughput: one transaction per cycle unless a poll stalls; the registers
//   form a two-stage flow, and the script state updates in the same cycle it is read.
// Start and unused commands produce no report and pass through without waiting on output.
// Reset (rst_n, async active low): button mode, string position 0, hold phase 0,
//   sleep start 0, wait registers at their documented defaults, both channels empty.
module hid_keystroke_macro_player_unit
    import hkmp_pkg::*;
#(
    parameter int STRING_DEPTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] now_ticks,
    input  logic        button_left,
    input  logic        button_right,

    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  modifier_bits,
    output logic [7:0]  key_slot_first,
    output logic [7:0]  key_slot_second
);

    logic [31:0]  wait_values [NUM_WAIT_REGS];

    // input stage
    logic         in_valid_reg;
    logic [1:0]   cmd_reg;
    logic [31:0]  now_ticks_reg;
    logic         button_left_reg;
    logic         button_right_reg;

    // output stage
    logic         out_valid_reg;
    hkmp_report_t report_reg;

    hkmp_item_t   item;
    logic         has_result;
    hkmp_report_t report;
    logic         out_free;
    logic         advance;
    logic         in_take;

    hkmp_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .wait_values (wait_values)
    );

    // The held transaction moves on when it needs no report slot, or when the
    // output register is empty or being drained this cycle.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && ((cmd_reg != CMD_POLL) || out_free);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign item.advance      = advance;
    assign item.cmd          = cmd_reg;
    assign item.now_ticks    = now_ticks_reg;
    assign item.button_left  = button_left_reg;
    assign item.button_right = button_right_reg;

    hkmp_engine #(
        .STRING_DEPTH (STRING_DEPTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .wait_values (wait_values),
        .has_result  (has_result),
        .report      (report)
    );

    // input register: control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // input register: payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg          <= cmd;
            now_ticks_reg    <= now_ticks;
            button_left_reg  <= button_left;
            button_right_reg <= button_right;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            report_reg <= report;
        end
    end

    assign out_valid       = out_valid_reg;
    assign modifier_bits   = report_reg.modifier_bits;
    assign key_slot_first  = report_reg.key_slot_first;
    assign key_slot_second = report_reg.key_slot_second;

endmodule
